### src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the DDA line rasteriser.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/dda_pkg.sv
// ---------------------------------------------------------------------------
// DDA rasteriser package
// Request and pixel payload types shared by the rasteriser modules.
// ---------------------------------------------------------------------------
package dda_pkg;

  localparam int FIELD_W = 6;
  localparam int INK_W   = 4;

  typedef struct packed {
    logic [FIELD_W-1:0] start_x;
    logic [FIELD_W-1:0] start_y;
    logic [FIELD_W-1:0] end_x;
    logic [FIELD_W-1:0] end_y;
    logic [INK_W-1:0]   ink;
  } dda_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] pixel_x;
    logic [FIELD_W-1:0] pixel_y;
    logic [INK_W-1:0]   pixel_ink;
    logic               last;
  } dda_out_t;

endpackage

### src/dda_line_rasterizer_top.sv
// ---------------------------------------------------------------------------
// DDA line rasteriser, top level
// Segment requests in, DDA pixels out, with a setup queue in between.
// ---------------------------------------------------------------------------
// Each request is one segment on a 2^COORD_BITS square tile; the block
// returns its DDA pixels in order, one per result, with last set on the
// final one. The step count L is the larger axis span; the first pixel is
// the start point, or one pixel below it on a decreasing axis, and a
// segment gives L results, while a segment with equal endpoints gives none.
// Increments carry FRAC_BITS fractional bits, truncated toward zero. On a
// shallow run toward row or column 0 the minor axis may floor to -1, which
// comes out as all ones. The front end takes a request, runs a bit-serial
// divider that forms both increments together, then pushes the setup into
// a two-entry queue; it takes no new request until that push is done. The
// stepper loads a setup and then emits one pixel per cycle while the
// output is not stalled. As the two halves overlap, the divider can work on
// the next segment while the stepper walks the current one.
module dda_line_rasterizer_top #(
  parameter int COORD_BITS = 6,
  parameter int FRAC_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dda_pkg::dda_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output dda_pkg::dda_out_t out_data
);
  import dda_pkg::*;

  `include "assert_macros.svh"

  // setup record: two accumulators, two increments, step count, ink
  localparam int REC_W = 2 * (COORD_BITS + FRAC_BITS + 2) + 2 * (FRAC_BITS + 2)
                         + COORD_BITS + INK_W;

  logic             q_push, q_pop, q_full, q_empty;
  logic [REC_W-1:0] q_wdata, q_rdata;

  // front: request decode and increment division
  dda_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .REC_W      (REC_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (q_push),
    .push_data (q_wdata),
    .q_full    (q_full)
  );

  // decoupling queue, lets the divider run ahead of the pixel run
  dda_queue #(
    .W (REC_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  // back: accumulator walk and output register
  dda_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .REC_W      (REC_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .pop_data  (q_rdata),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // queue overflow / underflow, and no gap inside a run
  `ASSERT_IMPL(a_no_push_full, clk, rst_n, q_push, !q_full, "push into full setup queue")
  `ASSERT_IMPL(a_no_pop_empty, clk, rst_n, q_pop, !q_empty, "pop from empty setup queue")
  `ASSERT_NEXT(a_run_no_gap, clk, rst_n, out_valid && out_ready && !out_data.last, out_valid, "bubble inside a pixel run")

endmodule

### src/dda_front.sv
// ---------------------------------------------------------------------------
// DDA front end
// Accepts a segment request, finds spans and step count, runs a bit-serial
// divider for both axis increments and pushes a setup record to the queue.
// ---------------------------------------------------------------------------
module dda_front #(
  parameter int COORD_BITS = 6,
  parameter int FRAC_BITS  = 16,
  parameter int REC_W      = 2 * (COORD_BITS + FRAC_BITS + 2) + 2 * (FRAC_BITS + 2)
                             + COORD_BITS + 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dda_pkg::dda_in_t     in_data,
  output logic                 push,
  output logic [REC_W-1:0]     push_data,
  input  logic                 q_full
);
  import dda_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int ACC_W = C + F + 2;
  localparam int INC_W = F + 2;
  localparam int DIV_N = C + F;
  localparam int CNT_W = $clog2(DIV_N + 1);

  typedef struct packed {
    logic signed [ACC_W-1:0] acc_x;
    logic signed [ACC_W-1:0] acc_y;
    logic signed [INC_W-1:0] inc_x;
    logic signed [INC_W-1:0] inc_y;
    logic [C-1:0]            steps;
    logic [INK_W-1:0]        ink;
  } rec_t;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_PUSH} state_t;

  state_t                  state_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [C-1:0]            steps_r;
  logic [C-1:0]            dvdx_r, dvdy_r;
  logic [C-1:0]            remx_r, remy_r;
  logic [F:0]              qx_r, qy_r;
  logic                    negx_r, negy_r;
  logic signed [ACC_W-1:0] accx_r, accy_r;
  logic [INK_W-1:0]        ink_r;

  // accept-time decode
  logic [C-1:0]            sx, sy, ex, ey, adx, ady, steps_in;
  logic                    posx, posy, negx, negy;
  logic signed [ACC_W-1:0] accx_in, accy_in, half_v;

  // divider step
  logic [C:0]              trialx, trialy;
  logic                    gex, gey;
  logic [C-1:0]            remx_nxt, remy_nxt;

  logic signed [INC_W-1:0] qxs, qys;
  rec_t                    rec;

  always_comb begin
    sx   = in_data.start_x[C-1:0];
    sy   = in_data.start_y[C-1:0];
    ex   = in_data.end_x[C-1:0];
    ey   = in_data.end_y[C-1:0];
    posx = ex > sx;
    negx = ex < sx;
    posy = ey > sy;
    negy = ey < sy;
    adx  = posx ? ex - sx : sx - ex;
    ady  = posy ? ey - sy : sy - ey;
    steps_in = (adx >= ady) ? adx : ady;
    half_v   = ACC_W'(1) <<< (F - 1);
    accx_in  = $signed({2'b00, sx, {F{1'b0}}});
    accy_in  = $signed({2'b00, sy, {F{1'b0}}});
    if (posx) begin
      accx_in = accx_in + half_v;
    end else if (negx) begin
      accx_in = accx_in - half_v;
    end
    if (posy) begin
      accy_in = accy_in + half_v;
    end else if (negy) begin
      accy_in = accy_in - half_v;
    end
  end

  // restoring division, one quotient bit a cycle on each axis
  always_comb begin
    trialx   = {remx_r, dvdx_r[C-1]};
    trialy   = {remy_r, dvdy_r[C-1]};
    gex      = trialx >= {1'b0, steps_r};
    gey      = trialy >= {1'b0, steps_r};
    remx_nxt = gex ? C'(trialx - {1'b0, steps_r}) : trialx[C-1:0];
    remy_nxt = gey ? C'(trialy - {1'b0, steps_r}) : trialy[C-1:0];
  end

  always_comb begin
    qxs       = $signed({1'b0, qx_r});
    qys       = $signed({1'b0, qy_r});
    rec.acc_x = accx_r;
    rec.acc_y = accy_r;
    rec.inc_x = negx_r ? -qxs : qxs;
    rec.inc_y = negy_r ? -qys : qys;
    rec.steps = steps_r;
    rec.ink   = ink_r;
    push_data = rec;
    push      = (state_r == S_PUSH) && !q_full;
    in_ready  = (state_r == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            steps_r <= steps_in;
            dvdx_r  <= adx;
            dvdy_r  <= ady;
            remx_r  <= '0;
            remy_r  <= '0;
            qx_r    <= '0;
            qy_r    <= '0;
            negx_r  <= negx;
            negy_r  <= negy;
            accx_r  <= accx_in;
            accy_r  <= accy_in;
            ink_r   <= in_data.ink;
            cnt_r   <= CNT_W'(DIV_N);
            // equal endpoints give no pixels: drop the request
            if (steps_in != '0) begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          remx_r <= remx_nxt;
          remy_r <= remy_nxt;
          qx_r   <= {qx_r[F-1:0], gex};
          qy_r   <= {qy_r[F-1:0], gey};
          dvdx_r <= {dvdx_r[C-2:0], 1'b0};
          dvdy_r <= {dvdy_r[C-2:0], 1'b0};
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!q_full) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### src/dda_queue.sv
// ---------------------------------------------------------------------------
// DDA setup queue
// Two-entry register FIFO between the front end and the pixel stepper.
// ---------------------------------------------------------------------------
module dda_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         empty
);
  import dda_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### src/dda_back.sv
// ---------------------------------------------------------------------------
// DDA pixel stepper
// Takes a setup record and walks both accumulators, one pixel per cycle
// while the output is not stalled, into a registered output stage.
// ---------------------------------------------------------------------------
module dda_back #(
  parameter int COORD_BITS = 6,
  parameter int FRAC_BITS  = 16,
  parameter int REC_W      = 2 * (COORD_BITS + FRAC_BITS + 2) + 2 * (FRAC_BITS + 2)
                             + COORD_BITS + 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  logic [REC_W-1:0]     pop_data,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dda_pkg::dda_out_t    out_data
);
  import dda_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int ACC_W = C + F + 2;
  localparam int INC_W = F + 2;

  typedef struct packed {
    logic signed [ACC_W-1:0] acc_x;
    logic signed [ACC_W-1:0] acc_y;
    logic signed [INC_W-1:0] inc_x;
    logic signed [INC_W-1:0] inc_y;
    logic [C-1:0]            steps;
    logic [INK_W-1:0]        ink;
  } rec_t;

  rec_t                    rec;
  logic                    busy_r;
  logic signed [ACC_W-1:0] accx_r, accy_r;
  logic signed [INC_W-1:0] incx_r, incy_r;
  logic [C-1:0]            cnt_r;
  logic [INK_W-1:0]        ink_r;
  logic                    out_valid_r;
  dda_out_t                out_r;
  logic                    adv;
  logic [C-1:0]            px, py;

  always_comb begin
    rec = rec_t'(pop_data);
    pop = !busy_r && !q_empty;
    adv = busy_r && (!out_valid_r || out_ready);
    // floor of a two's complement fixed-point value is its integer bits
    px  = accx_r[F+C-1:F];
    py  = accy_r[F+C-1:F];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (pop) begin
      accx_r <= rec.acc_x;
      accy_r <= rec.acc_y;
      incx_r <= rec.inc_x;
      incy_r <= rec.inc_y;
      cnt_r  <= rec.steps;
      ink_r  <= rec.ink;
    end else if (adv) begin
      accx_r <= accx_r + ACC_W'(incx_r);
      accy_r <= accy_r + ACC_W'(incy_r);
      cnt_r  <= cnt_r - 1'b1;
    end
    if (adv) begin
      out_r.pixel_x   <= FIELD_W'(px);
      out_r.pixel_y   <= FIELD_W'(py);
      out_r.pixel_ink <= ink_r;
      out_r.last      <= (cnt_r == C'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        busy_r <= 1'b1;
      end else if (adv && (cnt_r == C'(1))) begin
        busy_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
